@@ sv/assert_macros.svh @@
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is asserted
`define QAU_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked property that must also hold through reset
`define QAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/qau_pkg.sv @@
package qau_pkg;

  // opcodes
  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_DIV   = 4'd3;
  localparam logic [3:0] OP_CONJ  = 4'd4;
  localparam logic [3:0] OP_NORM  = 4'd5;
  localparam logic [3:0] OP_NEG   = 4'd6;
  localparam logic [3:0] OP_SCALE = 4'd7;
  localparam logic [3:0] OP_INV   = 4'd8;

  // divider geometry: 64-bit dividend, 33 quotient bits
  localparam int DIV_NW = 64;
  localparam int DIV_QW = 33;

  typedef logic [31:0] q16_t;

  // request as it travels down the pipeline
  typedef struct packed {
    logic [3:0]      op;
    q16_t [3:0]      a;
    q16_t [3:0]      b;
    q16_t            sf;
    logic            eq;
  } item_t;

  function automatic logic signed [65:0] sx66(input q16_t v);
    sx66 = {{34{v[31]}}, v};
  endfunction

  // clamp to the signed 32-bit range
  function automatic q16_t sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      sat32 = 32'h7fff_ffff;
    end else if (v < -66'sd2147483648) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

@@ sv/qau_divider.sv @@
module qau_divider import qau_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_NW-1:0] den_i,
  output logic [DIV_QW-1:0] quo_o
);

  logic [DIV_NW-1:0] rem_r [0:DIV_QW-1];
  logic [DIV_NW-1:0] num_r [0:DIV_QW-1];
  logic [DIV_NW-1:0] den_r [0:DIV_QW-1];
  logic [DIV_QW-1:0] quo_r [0:DIV_QW];

  // load: quotient is known to fit, so the top bits start the remainder
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {{DIV_QW{1'b0}}, num_i[DIV_NW-1:DIV_QW]};
      num_r[0] <= num_i;
      den_r[0] <= den_i;
      quo_r[0] <= '0;
    end
  end

  // one restoring step per stage, msb of the quotient first
  for (genvar k = 0; k < DIV_QW; k++) begin : g_step
    logic [DIV_NW:0]   trial;
    logic [DIV_NW:0]   diff;
    logic              ge;
    logic [DIV_QW-1:0] quo_nxt;

    always_comb begin
      trial   = {rem_r[k], num_r[k][DIV_QW-1-k]};
      diff    = trial - {1'b0, den_r[k]};
      ge      = (trial >= {1'b0, den_r[k]});
      quo_nxt = quo_r[k];
      quo_nxt[DIV_QW-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k+1] <= quo_nxt;
      end
    end

    if (k < DIV_QW-1) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= ge ? diff[DIV_NW-1:0] : trial[DIV_NW-1:0];
          num_r[k+1] <= num_r[k];
          den_r[k+1] <= den_r[k];
        end
      end
    end
  end

  assign quo_o = quo_r[DIV_QW];

endmodule

@@ sv/quaternion_arithmetic_unit_core.sv @@
// quaternion alu on signed q16.16 components, one request per clock
// input channel: in_valid / in_stall with op, operands a and b and the scale
// factor; a request is taken on a rising edge with in_valid high, in_stall low
// result channel: out_valid / out_stall with r_x..r_w, operands_equal and
// zero_magnitude; one result per request, in request order
// every opcode takes the same path from the accepting edge to out_valid
// throughput: one request per cycle while no result is held; the path runs
// through the 32-stage square root and then the 34-stage divider shared by
// normalize, inverse and divide, with the product and sum stages behind them
// stall: while out_valid is high and out_stall is high the whole pipeline
// holds, the result stays on the outputs and in_stall is raised; no request
// is lost or repeated
// reset: rst_n is synchronous and active low; it clears every valid bit,
// the pipeline is empty afterwards and in_stall drops at once
module quaternion_arithmetic_unit_core import qau_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_op,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_a_w,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic signed [31:0] in_b_w,
  input  logic signed [31:0] in_scale_factor,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_r_x,
  output logic signed [31:0] out_r_y,
  output logic signed [31:0] out_r_z,
  output logic signed [31:0] out_r_w,
  output logic               out_operands_equal,
  output logic               out_zero_magnitude
);

  localparam int SQ_STEPS = 32;

  function automatic logic signed [65:0] sx_prod(input logic signed [63:0] v);
    sx_prod = {{2{v[63]}}, v};
  endfunction

  logic adv;
  logic out_valid_r;

  // global advance: everything moves unless the output is held
  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // stage 0: input register
  logic  v0_r;
  item_t it0_r;
  item_t it0_nxt;

  always_comb begin
    it0_nxt.op = in_op;
    it0_nxt.a  = {in_a_w, in_a_z, in_a_y, in_a_x};
    it0_nxt.b  = {in_b_w, in_b_z, in_b_y, in_b_x};
    it0_nxt.sf = in_scale_factor;
    it0_nxt.eq = (in_a_x == in_b_x) && (in_a_y == in_b_y) &&
                 (in_a_z == in_b_z) && (in_a_w == in_b_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it0_r <= it0_nxt;
    end
  end

  // stage 1: squares of the operand whose magnitude is needed
  logic        v1_r;
  item_t       it1_r;
  logic [63:0] sq1_r [0:3];
  q16_t [3:0]  sqop;

  assign sqop = (it0_r.op == OP_DIV) ? it0_r.b : it0_r.a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1_r <= it0_r;
      for (int i = 0; i < 4; i++) begin
        sq1_r[i] <= $signed(sqop[i]) * $signed(sqop[i]);
      end
    end
  end

  // stage 2 and the square root pipeline; entry 0 holds the squared magnitude
  logic        sr_v_r    [0:SQ_STEPS];
  item_t       sr_it_r   [0:SQ_STEPS];
  logic [64:0] sr_mag_r  [0:SQ_STEPS];
  logic [31:0] sr_root_r [0:SQ_STEPS];
  logic [35:0] sr_rem_r  [0:SQ_STEPS-1];
  logic [64:0] mag_nxt;

  assign mag_nxt = {1'b0, sq1_r[0]} + {1'b0, sq1_r[1]} +
                   {1'b0, sq1_r[2]} + {1'b0, sq1_r[3]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_v_r[0] <= 1'b0;
    end else if (adv) begin
      sr_v_r[0] <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_it_r[0]   <= it1_r;
      sr_mag_r[0]  <= mag_nxt;
      sr_root_r[0] <= '0;
      sr_rem_r[0]  <= '0;
    end
  end

  // one bit pair of the low 64 bits per stage, top pair first
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        ge;
    logic [35:0] rem_nxt;
    logic [31:0] root_nxt;

    always_comb begin
      rem_sh   = {sr_rem_r[j][33:0], sr_mag_r[j][2*(SQ_STEPS-1-j) +: 2]};
      trial    = {2'b00, sr_root_r[j], 2'b01};
      ge       = (rem_sh >= trial);
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {sr_root_r[j][30:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sr_v_r[j+1] <= 1'b0;
      end else if (adv) begin
        sr_v_r[j+1] <= sr_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sr_it_r[j+1]   <= sr_it_r[j];
        sr_mag_r[j+1]  <= sr_mag_r[j];
        sr_root_r[j+1] <= root_nxt;
      end
    end

    if (j < SQ_STEPS-1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          sr_rem_r[j+1] <= rem_nxt;
        end
      end
    end
  end

  // divider set-up: normalize divides by the root, all other opcodes by the magnitude
  item_t             su_it;
  logic [64:0]       su_mag;
  logic              su_hi;
  logic              su_norm;
  q16_t [3:0]        su_q;
  logic [32:0]       su_root;
  logic [31:0]       su_abs [0:3];
  logic [DIV_NW-1:0] su_num [0:3];
  logic [DIV_NW-1:0] su_den;
  logic [3:0]        su_neg;
  logic              su_zero;

  always_comb begin
    su_it   = sr_it_r[SQ_STEPS];
    su_mag  = sr_mag_r[SQ_STEPS];
    su_hi   = su_mag[64];
    su_norm = (su_it.op == OP_NORM);
    su_q    = (su_it.op == OP_DIV) ? su_it.b : su_it.a;
    su_root = su_hi ? {1'b1, 32'd0} : {1'b0, sr_root_r[SQ_STEPS]};
    su_zero = (su_mag == '0);
    // with the carry set the inverse is zero, so keep the divisor non-zero
    if (su_norm) begin
      su_den = {31'd0, su_root};
    end else if (su_hi) begin
      su_den = '1;
    end else begin
      su_den = su_mag[63:0];
    end
    for (int i = 0; i < 4; i++) begin
      su_abs[i] = su_q[i][31] ? (~su_q[i] + 32'd1) : su_q[i];
      if (su_norm) begin
        su_num[i] = {16'd0, su_abs[i], 16'd0};
        su_neg[i] = su_q[i][31];
      end else begin
        su_num[i] = su_hi ? '0 : {su_abs[i], 32'd0};
        // conjugate flips the vector part
        su_neg[i] = (i == 3) ? su_q[i][31] : (!su_q[i][31] && (su_q[i] != '0));
      end
    end
  end

  // four divider lanes with the request carried alongside
  logic [DIV_QW-1:0] quo [0:3];
  logic              dl_v_r    [0:DIV_QW];
  item_t             dl_it_r   [0:DIV_QW];
  logic [3:0]        dl_neg_r  [0:DIV_QW];
  logic              dl_zero_r [0:DIV_QW];

  for (genvar i = 0; i < 4; i++) begin : g_lane
    qau_divider u_div (
      .clk   (clk),
      .en    (adv),
      .num_i (su_num[i]),
      .den_i (su_den),
      .quo_o (quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dl_v_r[0] <= 1'b0;
    end else if (adv) begin
      dl_v_r[0] <= sr_v_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dl_it_r[0]   <= su_it;
      dl_neg_r[0]  <= su_neg;
      dl_zero_r[0] <= su_zero;
    end
  end

  for (genvar k = 0; k < DIV_QW; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dl_v_r[k+1] <= 1'b0;
      end else if (adv) begin
        dl_v_r[k+1] <= dl_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dl_it_r[k+1]   <= dl_it_r[k];
        dl_neg_r[k+1]  <= dl_neg_r[k];
        dl_zero_r[k+1] <= dl_zero_r[k];
      end
    end
  end

  // sign and clamp of the quotients
  logic       t_v_r;
  item_t      t_it_r;
  logic       t_zero_r;
  q16_t [3:0] t_r;
  q16_t [3:0] t_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (quo[i][DIV_QW-1:31] != '0) begin
        t_nxt[i] = dl_neg_r[DIV_QW][i] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        t_nxt[i] = dl_neg_r[DIV_QW][i] ? (~quo[i][31:0] + 32'd1) : quo[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_v_r <= 1'b0;
    end else if (adv) begin
      t_v_r <= dl_v_r[DIV_QW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_it_r   <= dl_it_r[DIV_QW];
      t_zero_r <= dl_zero_r[DIV_QW];
      t_r      <= t_nxt;
    end
  end

  // products: hamilton terms against b or the inverse of b, and scaling
  logic               p_v_r;
  item_t              p_it_r;
  logic               p_zero_r;
  q16_t [3:0]         p_t_r;
  logic signed [63:0] p_h_r [0:3][0:3];
  logic signed [63:0] p_s_r [0:3];
  q16_t [3:0]         p_y;

  assign p_y = (t_it_r.op == OP_DIV) ? t_r : t_it_r.b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (adv) begin
      p_v_r <= t_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_it_r   <= t_it_r;
      p_zero_r <= t_zero_r;
      p_t_r    <= t_r;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p_h_r[i][j] <= $signed(t_it_r.a[i]) * $signed(p_y[j]);
        end
        p_s_r[i] <= $signed(t_it_r.a[i]) * $signed(t_it_r.sf);
      end
    end
  end

  // hamilton sums, exact
  logic               h_v_r;
  item_t              h_it_r;
  logic               h_zero_r;
  q16_t [3:0]         h_t_r;
  logic signed [63:0] h_s_r [0:3];
  logic signed [65:0] h_sum_r [0:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r <= 1'b0;
    end else if (adv) begin
      h_v_r <= p_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_it_r     <= p_it_r;
      h_zero_r   <= p_zero_r;
      h_t_r      <= p_t_r;
      h_s_r      <= p_s_r;
      h_sum_r[0] <= sx_prod(p_h_r[3][0]) + sx_prod(p_h_r[0][3]) +
                    sx_prod(p_h_r[1][2]) - sx_prod(p_h_r[2][1]);
      h_sum_r[1] <= sx_prod(p_h_r[3][1]) + sx_prod(p_h_r[1][3]) +
                    sx_prod(p_h_r[2][0]) - sx_prod(p_h_r[0][2]);
      h_sum_r[2] <= sx_prod(p_h_r[3][2]) + sx_prod(p_h_r[2][3]) +
                    sx_prod(p_h_r[0][1]) - sx_prod(p_h_r[1][0]);
      h_sum_r[3] <= sx_prod(p_h_r[3][3]) - sx_prod(p_h_r[0][0]) -
                    sx_prod(p_h_r[1][1]) - sx_prod(p_h_r[2][2]);
    end
  end

  // result selection by opcode, floor and saturation
  q16_t [3:0] res_r;
  q16_t [3:0] res_nxt;
  logic       eq_r;
  logic       zm_r;
  logic       zm_nxt;
  q16_t [3:0] ham;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ham[i] = sat32({{16{h_sum_r[i][65]}}, h_sum_r[i][65:16]});
    end
    zm_nxt = h_zero_r && (h_it_r.op inside {OP_DIV, OP_NORM, OP_INV});
    res_nxt = '0;
    case (h_it_r.op)
      OP_ADD: begin
        for (int i = 0; i < 4; i++) begin
          res_nxt[i] = sat32(sx66(h_it_r.a[i]) + sx66(h_it_r.b[i]));
        end
      end
      OP_SUB: begin
        for (int i = 0; i < 4; i++) begin
          res_nxt[i] = sat32(sx66(h_it_r.a[i]) - sx66(h_it_r.b[i]));
        end
      end
      OP_MUL: begin
        res_nxt = ham;
      end
      OP_DIV: begin
        res_nxt = h_zero_r ? '0 : ham;
      end
      OP_CONJ: begin
        for (int i = 0; i < 3; i++) begin
          res_nxt[i] = sat32(-sx66(h_it_r.a[i]));
        end
        res_nxt[3] = h_it_r.a[3];
      end
      OP_NORM, OP_INV: begin
        res_nxt = h_zero_r ? '0 : h_t_r;
      end
      OP_NEG: begin
        for (int i = 0; i < 4; i++) begin
          res_nxt[i] = sat32(-sx66(h_it_r.a[i]));
        end
      end
      OP_SCALE: begin
        for (int i = 0; i < 4; i++) begin
          res_nxt[i] = sat32({{18{h_s_r[i][63]}}, h_s_r[i][63:16]});
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= h_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      eq_r  <= h_it_r.eq;
      zm_r  <= zm_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_r_x            = res_r[0];
  assign out_r_y            = res_r[1];
  assign out_r_z            = res_r[2];
  assign out_r_w            = res_r[3];
  assign out_operands_equal = eq_r;
  assign out_zero_magnitude = zm_r;

endmodule

@@ sv/qau_checker.sv @@
`include "assert_macros.svh"

module qau_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_r_x,
  input logic signed [31:0] out_r_y,
  input logic signed [31:0] out_r_z,
  input logic signed [31:0] out_r_w,
  input logic               out_zero_magnitude
);

  // a held result stays valid
  `QAU_ASSERT(a_hold_valid, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")

  // a held result does not change
  `QAU_ASSERT(a_hold_data, clk, rst_n, out_valid && out_stall |=> $stable(out_r_x) && $stable(out_r_y) && $stable(out_r_z) && $stable(out_r_w), "result changed while stalled")

  // input side backs up exactly when the output is held
  `QAU_ASSERT_ALWAYS(a_stall_link, clk, in_stall == (out_valid && out_stall), "in_stall not tied to a held result")

  // zero magnitude always gives a zero quaternion
  `QAU_ASSERT(a_zero_result, clk, rst_n, out_valid && out_zero_magnitude |-> out_r_x == 0 && out_r_y == 0 && out_r_z == 0 && out_r_w == 0, "zero magnitude with non-zero result")

  // reset empties the pipeline
  `QAU_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind quaternion_arithmetic_unit_core qau_checker u_qau_checker (.*);

@@ tb/sv/tb_quaternion_arithmetic_unit_core.sv @@
module tb_quaternion_arithmetic_unit_core;
  import qau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 1550;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 150;
  localparam logic [3:0] OP_SPARE_LO = 4'd9;
  localparam logic [3:0] OP_SPARE_HI = 4'd15;

  typedef logic [3:0][31:0] quat_t;  // index 0 x, 1 y, 2 z, 3 w

  typedef struct {
    logic [3:0] op;
    quat_t      a;
    quat_t      b;
    logic [31:0] sf;
  } request_t;

  typedef struct {
    quat_t r;
    logic  eq;
    logic  zm;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [3:0] in_op = '0;
  logic signed [31:0] in_a_x = '0, in_a_y = '0, in_a_z = '0, in_a_w = '0;
  logic signed [31:0] in_b_x = '0, in_b_y = '0, in_b_z = '0, in_b_w = '0;
  logic signed [31:0] in_scale_factor = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_r_x, out_r_y, out_r_z, out_r_w;
  logic out_operands_equal, out_zero_magnitude;

  request_t pending_reqs[$];
  outcome_t awaited_results[$];
  request_t cur_req;
  int n_accepted = 0;
  int n_errors = 0;
  int gap_left = 0;
  int hold_left = 0;
  int stall_left = 0;
  bit long_hold_done = 1'b0;
  bit quiet = 1'b0;
  int n_cycles = 0;

  quaternion_arithmetic_unit_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z), .in_a_w(in_a_w),
    .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z), .in_b_w(in_b_w),
    .in_scale_factor(in_scale_factor),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_r_x(out_r_x), .out_r_y(out_r_y), .out_r_z(out_r_z), .out_r_w(out_r_w),
    .out_operands_equal(out_operands_equal), .out_zero_magnitude(out_zero_magnitude)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // clamp to the signed 32-bit range
  function automatic logic [31:0] clip32(input logic signed [97:0] v);
    if (v > 98'sd2147483647) return 32'h7fff_ffff;
    if (v < -98'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [97:0] wide(input logic [31:0] v);
    logic signed [97:0] w;
    w = $signed(v);
    return w;
  endfunction

  // exact four-term sum of q32.32 products, floored to q16.16
  function automatic logic [31:0] sum_floor(input logic signed [97:0] p0, p1, p2, p3);
    logic signed [97:0] s;
    s = p0 + p1 + p2 + p3;
    return clip32(s >>> 16);
  endfunction

  function automatic quat_t hamilton_product(input quat_t a, input quat_t b);
    quat_t r;
    r[0] = sum_floor(wide(a[3]) * wide(b[0]), wide(a[0]) * wide(b[3]),
                     wide(a[1]) * wide(b[2]), -(wide(a[2]) * wide(b[1])));
    r[1] = sum_floor(wide(a[3]) * wide(b[1]), wide(a[1]) * wide(b[3]),
                     wide(a[2]) * wide(b[0]), -(wide(a[0]) * wide(b[2])));
    r[2] = sum_floor(wide(a[3]) * wide(b[2]), wide(a[2]) * wide(b[3]),
                     wide(a[0]) * wide(b[1]), -(wide(a[1]) * wide(b[0])));
    r[3] = sum_floor(wide(a[3]) * wide(b[3]), -(wide(a[0]) * wide(b[0])),
                     -(wide(a[1]) * wide(b[1])), -(wide(a[2]) * wide(b[2])));
    return r;
  endfunction

  function automatic logic [97:0] norm_sq(input quat_t q);
    logic signed [97:0] s;
    s = '0;
    for (int i = 0; i < 4; i++) s += wide(q[i]) * wide(q[i]);
    return s;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'h1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // apply a sign to a magnitude quotient, then clamp
  function automatic logic [31:0] signed_quot(input bit neg, input logic [97:0] m);
    logic signed [97:0] v;
    if (m > 98'h8000_0000) m = 98'h8000_0000;
    v = $signed(m);
    return clip32(neg ? -v : v);
  endfunction

  function automatic quat_t quat_inverse(input quat_t q);
    quat_t r;
    logic [97:0] s, m, quo;
    logic signed [97:0] c;
    s = norm_sq(q);
    for (int i = 0; i < 4; i++) begin
      c = (i == 3) ? wide(q[i]) : -wide(q[i]);
      m = (c < 0) ? -c : c;
      quo = (s >= 98'h1_0000_0000_0000_0000) ? '0 : (m << 32) / s;
      r[i] = signed_quot(c < 0, quo);
    end
    return r;
  endfunction

  function automatic quat_t quat_normalize(input quat_t q);
    quat_t r;
    logic [97:0] s, root, m;
    logic signed [97:0] c;
    s = norm_sq(q);
    root = (s >= 98'h1_0000_0000_0000_0000) ? 98'h1_0000_0000 : int_sqrt(s[63:0]);
    if (root == 0) root = 1;
    for (int i = 0; i < 4; i++) begin
      c = wide(q[i]);
      m = (c < 0) ? -c : c;
      r[i] = signed_quot(c < 0, (m << 16) / root);
    end
    return r;
  endfunction

  // expected result of one request
  function automatic outcome_t quat_alu_result(input request_t q);
    outcome_t o;
    o.r = '0;
    o.zm = 1'b0;
    o.eq = (q.a == q.b);
    case (q.op)
      OP_ADD: for (int i = 0; i < 4; i++) o.r[i] = clip32(wide(q.a[i]) + wide(q.b[i]));
      OP_SUB: for (int i = 0; i < 4; i++) o.r[i] = clip32(wide(q.a[i]) - wide(q.b[i]));
      OP_MUL: o.r = hamilton_product(q.a, q.b);
      OP_DIV: begin
        if (q.b == '0) o.zm = 1'b1;
        else o.r = hamilton_product(q.a, quat_inverse(q.b));
      end
      OP_CONJ: begin
        for (int i = 0; i < 3; i++) o.r[i] = clip32(-wide(q.a[i]));
        o.r[3] = q.a[3];
      end
      OP_NORM: begin
        if (q.a == '0) o.zm = 1'b1;
        else o.r = quat_normalize(q.a);
      end
      OP_NEG: for (int i = 0; i < 4; i++) o.r[i] = clip32(-wide(q.a[i]));
      OP_SCALE: for (int i = 0; i < 4; i++) o.r[i] = clip32((wide(q.a[i]) * wide(q.sf)) >>> 16);
      OP_INV: begin
        if (q.a == '0) o.zm = 1'b1;
        else o.r = quat_inverse(q.a);
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic logic [31:0] rand_comp(input int kind);
    logic [31:0] v;
    case (kind)
      0: v = $urandom;
      1: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      2: v = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      default: begin
        case ($urandom_range(0, 5))
          0: v = 32'h0;
          1: v = 32'h1;
          2: v = 32'hffff_ffff;
          3: v = 32'h7fff_ffff;
          4: v = 32'h8000_0000;
          default: v = 32'h0001_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic quat_t rand_quat();
    quat_t q;
    int kind;
    kind = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) q[i] = rand_comp(kind);
    return q;
  endfunction

  task automatic queue_req(input logic [3:0] op, input quat_t a, input quat_t b,
                           input logic [31:0] sf);
    request_t q;
    q.op = op; q.a = a; q.b = b; q.sf = sf;
    pending_reqs.push_back(q);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(quat_alu_result(cur_req));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0 && !quiet && ((n_accepted / 100) % 3 != 0)
                     && $urandom_range(0, 5) == 0) begin
          gap_left <= $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          cur_req = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_op <= cur_req.op;
          in_a_x <= cur_req.a[0]; in_a_y <= cur_req.a[1];
          in_a_z <= cur_req.a[2]; in_a_w <= cur_req.a[3];
          in_b_x <= cur_req.b[0]; in_b_y <= cur_req.b[1];
          in_b_z <= cur_req.b[2]; in_b_w <= cur_req.b[3];
          in_scale_factor <= cur_req.sf;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall: random bursts plus one long hold-off
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= (hold_left > 1);
      end else if (!long_hold_done && n_accepted >= 300) begin
        long_hold_done <= 1'b1;
        hold_left <= 300;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= (stall_left > 1);
      end else if (!quiet && ((n_accepted / 100) % 3 != 1) && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(1, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    outcome_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        $error("result with no request outstanding");
        n_errors++;
      end else begin
        e = awaited_results.pop_front();
        if (out_r_x !== e.r[0]) begin
          $error("r_x expected %h actual %h", e.r[0], out_r_x); n_errors++;
        end
        if (out_r_y !== e.r[1]) begin
          $error("r_y expected %h actual %h", e.r[1], out_r_y); n_errors++;
        end
        if (out_r_z !== e.r[2]) begin
          $error("r_z expected %h actual %h", e.r[2], out_r_z); n_errors++;
        end
        if (out_r_w !== e.r[3]) begin
          $error("r_w expected %h actual %h", e.r[3], out_r_w); n_errors++;
        end
        if (out_operands_equal !== e.eq) begin
          $error("operands_equal expected %b actual %b", e.eq, out_operands_equal);
          n_errors++;
        end
        if (out_zero_magnitude !== e.zm) begin
          $error("zero_magnitude expected %b actual %b", e.zm, out_zero_magnitude);
          n_errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    quat_t z, mx, mn, one, qi, qj, tiny, big;
    logic [3:0] op;
    quat_t a, b;
    z = '0;
    mx = {4{32'h7fff_ffff}};
    mn = {4{32'h8000_0000}};
    one = {32'h0001_0000, 32'h0, 32'h0, 32'h0};
    qi = {32'h0, 32'h0, 32'h0, 32'h0001_0000};
    qj = {32'h0, 32'h0, 32'h0001_0000, 32'h0};
    tiny = {32'h0, 32'h0, 32'h0, 32'h1};
    big = {32'h0, 32'h0, 32'h0, 32'h7fff_ffff};

    // directed: field extremes, every operation, zero magnitude and saturation
    queue_req(OP_ADD, mx, mx, 32'h0);
    queue_req(OP_ADD, mn, mn, 32'hffff_ffff);
    queue_req(OP_SUB, mn, mx, 32'h0);
    queue_req(OP_MUL, qi, qj, 32'h0);
    queue_req(OP_MUL, mn, mn, 32'h0);
    queue_req(OP_MUL, mx, mn, 32'h0);
    queue_req(OP_DIV, qi, z, 32'h0);
    queue_req(OP_DIV, qi, qj, 32'h0);
    queue_req(OP_DIV, mx, tiny, 32'h0);
    queue_req(OP_DIV, one, mn, 32'h0);
    queue_req(OP_CONJ, mn, z, 32'h0);
    queue_req(OP_NORM, z, z, 32'h0);
    queue_req(OP_NORM, {32'h0003_0000, 32'h0004_0000, 32'h0, 32'h0}, z, 32'h0);
    queue_req(OP_NORM, mn, z, 32'h0);
    queue_req(OP_NORM, tiny, z, 32'h0);
    queue_req(OP_NEG, mn, z, 32'h0);
    queue_req(OP_SCALE, mx, z, 32'h7fff_ffff);
    queue_req(OP_SCALE, mn, z, 32'h8000_0000);
    queue_req(OP_SCALE, one, z, 32'hffff_8000);
    queue_req(OP_INV, z, z, 32'h0);
    queue_req(OP_INV, tiny, z, 32'h0);
    queue_req(OP_INV, big, z, 32'h0);
    queue_req(OP_INV, one, one, 32'h0);
    queue_req(OP_SPARE_LO, mx, mx, 32'h0);
    queue_req(OP_SPARE_HI, mn, z, 32'h0);

    // random: mostly valid opcodes with sized operands, some special shapes
    for (int n = 0; n < N_RANDOM; n++) begin
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
      a = rand_quat();
      b = rand_quat();
      case ($urandom_range(0, 9))
        0: b = a;
        1: b[3] = '0;
        2: if (op == OP_DIV) b = '0; else a = '0;
        default: ;
      endcase
      queue_req(op, a, b, rand_comp($urandom_range(0, 3)));
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() > 200) @(posedge clk);
    quiet = 1'b1;
    while (pending_reqs.size() != 0 || in_valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && awaited_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
